>>> sv/gawct_pkg.sv
// Shared types, constants and helpers for the global alignment block.
`default_nettype none
package gawct_pkg;

  localparam int MaxLenADef = 16;
  localparam int MaxLenBDef = 16;

  localparam int ScoreW = 22;
  localparam int SumW   = 23;

  localparam logic signed [15:0] GapReset  = 16'sd1;
  localparam logic [4:0]         LenReset  = 5'd16;

  // request codes
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_COST   = 2'd2;
  localparam logic [1:0] REQ_RUN    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP   = 2'd0;
  localparam logic [1:0] CFG_LEN_A = 2'd1;
  localparam logic [1:0] CFG_LEN_B = 2'd2;

  // traceback directions
  localparam logic [1:0] DIR_DIAG = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_UP   = 2'd3;

  // clamp a sum to the score range
  function automatic logic signed [ScoreW-1:0] sat_score(input logic signed [SumW-1:0] v);
    logic signed [ScoreW-1:0] r;
    if (v[SumW-1] != v[SumW-2]) begin
      r = v[SumW-1] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    end else begin
      r = v[ScoreW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/gawct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gawct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/global_alignment_with_cost_table.sv
// Global alignment engine: string and cost loads, table fill, traceback.
// Load items give no result.
// A run fills the border row, then per row updates column 0 and, per cell, reads the
// cost and adds diagonal, left and up on one shared adder, then walks the traceback into a
// stack and emits 1 + pairs results, cost first. The block accepts no item during a run.
// Reset (rst_ni low, asynchronous): idle, gap 1, lengths 16; memories keep their contents.
`default_nettype none
module global_alignment_with_cost_table
  import gawct_pkg::*;
#(
  parameter int MAX_LEN_A = MaxLenADef,
  parameter int MAX_LEN_B = MaxLenBDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [3:0]         row_index_i,
  input  wire logic [3:0]         col_index_i,
  input  wire logic [7:0]         char_value_i,
  input  wire logic signed [15:0] cost_value_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    result_kind_o,
  output logic signed [21:0]      total_cost_o,
  output logic [7:0]              char_a_o,
  output logic [7:0]              char_b_o,
  output logic                    a_present_o,
  output logic                    b_present_o,
  output logic                    last_o
);

  localparam int AAW = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
  localparam int BAW = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
  localparam int CAW = (MAX_LEN_A * MAX_LEN_B > 1) ? $clog2(MAX_LEN_A * MAX_LEN_B) : 1;
  localparam int SAW = $clog2(MAX_LEN_B + 1);
  localparam int KW  = $clog2(MAX_LEN_A + MAX_LEN_B);
  localparam int NW  = $clog2(MAX_LEN_A + MAX_LEN_B + 1);
  localparam int IW  = $clog2(MAX_LEN_A + 1);
  localparam int JW  = $clog2(MAX_LEN_B + 1);
  localparam int EW  = 18;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_BORDER   = 5'd1;
  localparam logic [4:0] S_ROW_RD   = 5'd2;
  localparam logic [4:0] S_ROW_WR   = 5'd3;
  localparam logic [4:0] S_CELL_RD  = 5'd4;
  localparam logic [4:0] S_CELL_A   = 5'd5;
  localparam logic [4:0] S_CELL_B   = 5'd6;
  localparam logic [4:0] S_CELL_D   = 5'd7;
  localparam logic [4:0] S_TB_RD    = 5'd8;
  localparam logic [4:0] S_TB_WAIT  = 5'd9;
  localparam logic [4:0] S_FIN_RD   = 5'd10;
  localparam logic [4:0] S_FIN_WAIT = 5'd11;
  localparam logic [4:0] S_COST_OUT = 5'd12;
  localparam logic [4:0] S_POP_RD   = 5'd13;
  localparam logic [4:0] S_POP_LOAD = 5'd14;
  localparam logic [4:0] S_POP_OUT  = 5'd15;

  logic [4:0] state_q, state_d;
  logic signed [15:0] gap_q;
  logic [4:0] len_a_q, len_b_q;
  logic [IW-1:0] la_q, la_d, i_q, i_d;
  logic [JW-1:0] lb_q, lb_d, j_q, j_d;
  logic [NW-1:0] n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic out_valid_q, out_valid_d;

  logic signed [ScoreW-1:0] acc_q, acc_d, diag_q, diag_d, left_q, left_d, up_q, up_d;
  logic signed [SumW-1:0] a_q, a_d, b_q, b_d;
  logic kind_q, kind_d, pa_q, pa_d, pb_q, pb_d, last_q, last_d;
  logic signed [ScoreW-1:0] total_q, total_d;
  logic [7:0] ca_q, ca_d, cb_q, cb_d;

  // memory ports
  logic           sa_we, sb_we, cost_we, score_we, dir_we, stk_we;
  logic [AAW-1:0] sa_waddr, sa_raddr;
  logic [BAW-1:0] sb_waddr, sb_raddr;
  logic [CAW-1:0] cost_waddr, cell_idx;
  logic [SAW-1:0] score_waddr, score_raddr;
  logic [KW-1:0]  stk_raddr;
  logic [7:0]     sa_rdata, sb_rdata;
  logic [15:0]    cost_rdata;
  logic [ScoreW-1:0] score_wdata, score_rdata;
  logic [1:0]     dir_wdata, dir_rdata;
  logic [EW-1:0]  stk_wdata, stk_rdata;

  logic in_acc, out_acc, row_last;
  logic signed [SumW-1:0] add_a, add_b, add_sum;
  logic signed [ScoreW-1:0] best_sat;
  logic signed [SumW-1:0] best;
  logic [1:0] pick_dir, tb_dir;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign row_last    = (32'(i_q) == 32'(la_q));

  assign cell_idx = CAW'((32'(i_q) - 32'd1) * MAX_LEN_B + 32'(j_q) - 32'd1);

  // shared adder operand select
  always_comb begin
    add_a = SumW'(acc_q);
    add_b = SumW'(gap_q);
    case (state_q)
      S_ROW_WR: add_a = SumW'($signed(score_rdata));
      S_CELL_A: begin
        add_a = SumW'(diag_q);
        add_b = SumW'($signed(cost_rdata));
      end
      S_CELL_B: add_a = SumW'(left_q);
      S_CELL_D: add_a = SumW'(up_q);
      default: add_a = SumW'(acc_q);
    endcase
  end
  assign add_sum = add_a + add_b;

  // minimum with ties to diagonal, then left
  always_comb begin
    if (a_q <= b_q && a_q <= add_sum) begin
      best = a_q;
      pick_dir = DIR_DIAG;
    end else if (b_q <= add_sum) begin
      best = b_q;
      pick_dir = DIR_LEFT;
    end else begin
      best = add_sum;
      pick_dir = DIR_UP;
    end
  end
  assign best_sat = sat_score(best);

  always_comb begin
    if (i_q == '0) begin
      tb_dir = DIR_LEFT;
    end else if (j_q == '0) begin
      tb_dir = DIR_UP;
    end else begin
      tb_dir = dir_rdata;
    end
  end

  // memory port control
  always_comb begin
    sa_we      = in_acc && req_type_i == REQ_LOAD_A && 32'(row_index_i) < MAX_LEN_A;
    sb_we      = in_acc && req_type_i == REQ_LOAD_B && 32'(col_index_i) < MAX_LEN_B;
    cost_we    = in_acc && req_type_i == REQ_COST && 32'(row_index_i) < MAX_LEN_A
                 && 32'(col_index_i) < MAX_LEN_B;
    sa_waddr   = AAW'(row_index_i);
    sb_waddr   = BAW'(col_index_i);
    cost_waddr = CAW'(32'(row_index_i) * MAX_LEN_B + 32'(col_index_i));
    sa_raddr   = AAW'(32'(i_q) - 32'd1);
    sb_raddr   = BAW'(32'(j_q) - 32'd1);

    score_we    = 1'b0;
    score_waddr = SAW'(j_q);
    score_wdata = acc_q;
    case (state_q)
      S_BORDER: score_we = 1'b1;
      S_ROW_WR: begin
        score_we    = 1'b1;
        score_waddr = '0;
        score_wdata = sat_score(add_sum);
      end
      S_CELL_D: begin
        score_we    = 1'b1;
        score_wdata = best_sat;
      end
      default: score_we = 1'b0;
    endcase

    case (state_q)
      S_ROW_RD: score_raddr = '0;
      S_FIN_RD: score_raddr = SAW'(lb_q);
      default:  score_raddr = SAW'(j_q);
    endcase

    dir_we    = (state_q == S_CELL_D);
    dir_wdata = pick_dir;
    stk_we    = (state_q == S_TB_WAIT);
    stk_wdata = {tb_dir != DIR_LEFT, (tb_dir != DIR_LEFT) ? sa_rdata : 8'd0,
                 tb_dir != DIR_UP,   (tb_dir != DIR_UP)   ? sb_rdata : 8'd0};
    stk_raddr = k_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    la_d = la_q; lb_d = lb_q; i_d = i_q; j_d = j_q; n_d = n_q; k_d = k_q;
    acc_d = acc_q; diag_d = diag_q; left_d = left_q; up_d = up_q;
    a_d = a_q; b_d = b_q;
    out_valid_d = out_valid_q;
    kind_d = kind_q; total_d = total_q; ca_d = ca_q; cb_d = cb_q;
    pa_d = pa_q; pb_d = pb_q; last_d = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && req_type_i == REQ_RUN) begin
          la_d    = (32'(len_a_q) > MAX_LEN_A) ? IW'(MAX_LEN_A) : IW'(len_a_q);
          lb_d    = (32'(len_b_q) > MAX_LEN_B) ? JW'(MAX_LEN_B) : JW'(len_b_q);
          acc_d   = '0;
          j_d     = '0;
          n_d     = '0;
          state_d = S_BORDER;
        end
      end
      S_BORDER: begin
        acc_d = sat_score(add_sum);
        if (j_q == lb_q) begin
          if (la_q == '0) begin
            i_d = la_q; j_d = lb_q; n_d = '0;
            state_d = S_TB_RD;
          end else begin
            i_d = IW'(1);
            state_d = S_ROW_RD;
          end
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      S_ROW_RD: state_d = S_ROW_WR;
      S_ROW_WR: begin
        diag_d = $signed(score_rdata);
        left_d = sat_score(add_sum);
        j_d    = JW'(1);
        if (lb_q != '0) begin
          state_d = S_CELL_RD;
        end else if (row_last) begin
          i_d = la_q; j_d = lb_q; n_d = '0;
          state_d = S_TB_RD;
        end else begin
          i_d = i_q + IW'(1);
          state_d = S_ROW_RD;
        end
      end
      S_CELL_RD: state_d = S_CELL_A;
      S_CELL_A: begin
        up_d    = $signed(score_rdata);
        a_d     = add_sum;
        state_d = S_CELL_B;
      end
      S_CELL_B: begin
        b_d     = add_sum;
        state_d = S_CELL_D;
      end
      S_CELL_D: begin
        diag_d = up_q;
        left_d = best_sat;
        if (j_q != lb_q) begin
          j_d = j_q + JW'(1);
          state_d = S_CELL_RD;
        end else if (row_last) begin
          i_d = la_q; j_d = lb_q; n_d = '0;
          state_d = S_TB_RD;
        end else begin
          i_d = i_q + IW'(1);
          state_d = S_ROW_RD;
        end
      end
      S_TB_RD: begin
        state_d = (i_q == '0 && j_q == '0) ? S_FIN_RD : S_TB_WAIT;
      end
      S_TB_WAIT: begin
        if (tb_dir != DIR_UP) j_d = j_q - JW'(1);
        if (tb_dir != DIR_LEFT) i_d = i_q - IW'(1);
        n_d = n_q + NW'(1);
        state_d = S_TB_RD;
      end
      S_FIN_RD: state_d = S_FIN_WAIT;
      S_FIN_WAIT: begin
        out_valid_d = 1'b1;
        kind_d  = 1'b0;
        total_d = $signed(score_rdata);
        ca_d = '0; cb_d = '0; pa_d = 1'b0; pb_d = 1'b0;
        last_d  = (n_q == '0);
        state_d = S_COST_OUT;
      end
      S_COST_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          k_d = KW'(32'(n_q) - 32'd1);
          state_d = (n_q == '0) ? S_IDLE : S_POP_RD;
        end
      end
      S_POP_RD: state_d = S_POP_LOAD;
      S_POP_LOAD: begin
        out_valid_d = 1'b1;
        kind_d  = 1'b1;
        total_d = '0;
        {pa_d, ca_d, pb_d, cb_d} = stk_rdata;
        last_d  = (k_q == '0);
        state_d = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (k_q == '0) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q - KW'(1);
            state_d = S_POP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gap_q       <= GapReset;
      len_a_q     <= LenReset;
      len_b_q     <= LenReset;
      la_q <= '0; lb_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0; k_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      la_q <= la_d; lb_q <= lb_d; i_q <= i_d; j_q <= j_d; n_q <= n_d; k_q <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GAP:   gap_q   <= $signed(cfg_data_i);
          CFG_LEN_A: len_a_q <= cfg_data_i[4:0];
          CFG_LEN_B: len_b_q <= cfg_data_i[4:0];
          default:   gap_q   <= gap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; diag_q <= diag_d; left_q <= left_d; up_q <= up_d;
    a_q <= a_d; b_q <= b_d;
    kind_q <= kind_d; total_q <= total_d; ca_q <= ca_d; cb_q <= cb_d;
    pa_q <= pa_d; pb_q <= pb_d; last_q <= last_d;
  end

  gawct_ram #(.WIDTH(8), .DEPTH(MAX_LEN_A)) u_str_a (
    .clk_i, .we_i(sa_we), .waddr_i(sa_waddr), .wdata_i(char_value_i),
    .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );

  gawct_ram #(.WIDTH(8), .DEPTH(MAX_LEN_B)) u_str_b (
    .clk_i, .we_i(sb_we), .waddr_i(sb_waddr), .wdata_i(char_value_i),
    .raddr_i(sb_raddr), .rdata_o(sb_rdata)
  );

  gawct_ram #(.WIDTH(16), .DEPTH(MAX_LEN_A * MAX_LEN_B)) u_cost (
    .clk_i, .we_i(cost_we), .waddr_i(cost_waddr), .wdata_i(cost_value_i),
    .raddr_i(cell_idx), .rdata_o(cost_rdata)
  );

  gawct_ram #(.WIDTH(ScoreW), .DEPTH(MAX_LEN_B + 1)) u_score (
    .clk_i, .we_i(score_we), .waddr_i(score_waddr), .wdata_i(score_wdata),
    .raddr_i(score_raddr), .rdata_o(score_rdata)
  );

  gawct_ram #(.WIDTH(2), .DEPTH(MAX_LEN_A * MAX_LEN_B)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(cell_idx), .wdata_i(dir_wdata),
    .raddr_i(cell_idx), .rdata_o(dir_rdata)
  );

  gawct_ram #(.WIDTH(EW), .DEPTH(MAX_LEN_A + MAX_LEN_B)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(n_q[KW-1:0]), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign total_cost_o  = total_q;
  assign char_a_o      = ca_q;
  assign char_b_o      = cb_q;
  assign a_present_o   = pa_q;
  assign b_present_o   = pb_q;
  assign last_o        = last_q;

  a_no_accept_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted while a result is pending");

  a_pair_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |-> (a_present_o || b_present_o))
    else $error("aligned pair with dash on both sides");

  a_path_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(n_q) <= 32'(la_q) + 32'(lb_q)))
    else $error("traceback longer than both strings");

endmodule
`default_nettype wire
